// File: src/arb_pkg.sv
// Shared codes and small types for the arcball rotation block.
// No dependencies; every other file except arb_if imports this package.
package arb_pkg;

  localparam int CFG_INDEX_W = 2;
  localparam int CFG_DATA_W  = 32;
  localparam int EPS_W       = 32;

  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_X    = 2'd0;
  localparam logic [CFG_INDEX_W-1:0] REG_SCALE_Y    = 2'd1;
  localparam logic [CFG_INDEX_W-1:0] REG_EPSILON_SQ = 2'd2;

  localparam logic ACT_PRESS = 1'b0;
  localparam logic ACT_DRAG  = 1'b1;

  typedef enum logic [1:0] {
    MAC_HOLD,
    MAC_LOAD,
    MAC_ADD,
    MAC_SUB
  } mac_op_t;

  typedef enum logic {
    ITER_SQRT,
    ITER_DIV
  } iter_mode_t;

  typedef struct packed {
    logic       start;
    iter_mode_t mode;
  } iter_ctl_t;

endpackage

// File: src/arb_if.sv
// Request and result channel interfaces of the arcball rotation block.
// Depends on nothing; widths come from interface parameters.
interface arb_in_if #(parameter int COORD_BITS = 12);
  logic                  valid;
  logic                  ready;
  logic                  action;
  logic [COORD_BITS-1:0] pointer_x;
  logic [COORD_BITS-1:0] pointer_y;
  modport source (output valid, action, pointer_x, pointer_y, input ready);
  modport sink   (input valid, action, pointer_x, pointer_y, output ready);
endinterface

interface arb_out_if #(parameter int FRAC_BITS = 16);
  logic                        valid;
  logic                        ready;
  logic signed [FRAC_BITS+1:0] rot_x;
  logic signed [FRAC_BITS+1:0] rot_y;
  logic signed [FRAC_BITS+1:0] rot_z;
  logic signed [FRAC_BITS+1:0] rot_w;
  modport source (output valid, rot_x, rot_y, rot_z, rot_w, input ready);
  modport sink   (input valid, rot_x, rot_y, rot_z, rot_w, output ready);
endinterface

// File: src/arb_mac.sv
// Shared signed multiply-accumulate unit of the arcball block.
// Depends on arb_pkg for the operation codes.
module arb_mac import arb_pkg::*; #(
  parameter int MW = 27
) (
  input  logic                     clk,
  input  mac_op_t                  op,
  input  logic signed [MW-1:0]     a,
  input  logic signed [MW-1:0]     b,
  output logic signed [2*MW+1:0]   acc
);
  logic signed [2*MW-1:0] prod;
  logic signed [2*MW+1:0] prod_x;

  assign prod   = a * b;
  assign prod_x = {{2{prod[2*MW-1]}}, prod};

  always_ff @(posedge clk) begin
    case (op)
      MAC_LOAD: acc <= prod_x;
      MAC_ADD:  acc <= acc + prod_x;
      MAC_SUB:  acc <= acc - prod_x;
      default:  acc <= acc;
    endcase
  end
endmodule

// File: src/arb_iter.sv
// Shared bit-serial unit: integer square root (two radicand bits a step)
// and restoring division (one quotient bit a step). Depends on arb_pkg.
module arb_iter import arb_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic                       clk,
  input  logic                       rst,
  input  iter_ctl_t                  ctl,
  input  logic [2*FRAC_BITS+3:0]     radicand,
  input  logic [2*FRAC_BITS+1:0]     numer,
  input  logic [FRAC_BITS+1:0]       denom,
  output logic                       done,
  output logic [FRAC_BITS+1:0]       res
);
  localparam int QB    = FRAC_BITS + 2;
  localparam int RW    = FRAC_BITS + 5;
  localparam int SW    = 2*FRAC_BITS + 4;
  localparam int NW    = 2*FRAC_BITS + 2;
  localparam int CNT_W = $clog2(QB + 1);

  logic             busy;
  logic [CNT_W-1:0] cnt;
  iter_mode_t       mode_q;
  logic [RW-1:0]    rem;
  logic [SW-1:0]    src;
  logic [QB-1:0]    den_q;
  logic [RW-1:0]    cand;
  logic [RW-1:0]    sub;
  logic             ge;

  always_comb begin
    if (mode_q == ITER_SQRT) begin
      cand = {rem[RW-3:0], src[SW-1:SW-2]};
      sub  = {1'b0, res, 2'b01};
    end else begin
      cand = {rem[RW-2:0], src[SW-1]};
      sub  = {3'b000, den_q};
    end
    ge = (cand >= sub);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt  <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start) begin
        busy <= 1'b1;
        cnt  <= '0;
      end else if (busy) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(QB - 1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.start) begin
      mode_q <= ctl.mode;
      res    <= '0;
      den_q  <= denom;
      if (ctl.mode == ITER_SQRT) begin
        rem <= '0;
        src <= radicand;
      end else begin
        rem <= {5'b00000, numer[NW-1:QB]};
        src <= {numer[QB-1:0], {(SW-QB){1'b0}}};
      end
    end else if (busy) begin
      rem <= ge ? (cand - sub) : cand;
      res <= {res[QB-2:0], ge};
      if (mode_q == ITER_SQRT) src <= src << 2;
      else                     src <= src << 1;
    end
  end
endmodule

// File: src/arcball_rotation_quaternion_unit.sv
// Top level of the arcball rotation block: sequencer, vector registers.
// Depends on arb_pkg, arb_if, arb_mac and arb_iter.
//
//  channel   dir  handshake      payload
//  pointer   in   valid/ready    action, pointer_x, pointer_y
//  rotation  out  valid/ready    rot_x, rot_y, rot_z, rot_w
//  config    in   cfg_we         cfg_index, cfg_data
//
// A press inside the circle needs one square root; outside it also needs two
// divides; a drag adds the cross and dot products. The bit-serial
// root/divide unit sets the pace, one result bit per cycle.
// Reset is synchronous; no clearing pass. A new request is taken while the
// last result still waits; a stalled result holds the block before delivery.
module arcball_rotation_quaternion_unit import arb_pkg::*; #(
  parameter int COORD_BITS = 12,
  parameter int FRAC_BITS  = 16
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   cfg_we,
  input  logic [CFG_INDEX_W-1:0] cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  arb_in_if.sink                 pointer,
  arb_out_if.source              rotation
);
  localparam int F     = FRAC_BITS;
  localparam int OW    = F + 2;
  localparam int MXW   = F + 3;
  localparam int MW    = (COORD_BITS + 1 > F + 3) ? COORD_BITS + 1 : F + 3;
  localparam int ACC_W = 2*MW + 2;
  localparam int LW    = 2*F + 4;
  localparam int NW    = 2*F + 2;
  localparam int TWO_F = 2*F;
  localparam int CW    = ((TWO_F > 32) ? TWO_F : 32) + 4;
  localparam int SH_L  = (TWO_F < 32) ? 32 - TWO_F : 0;
  localparam int SH_R  = (TWO_F >= 32) ? TWO_F - 32 : 0;

  localparam logic signed [ACC_W-1:0] ONE_A   = ACC_W'(64'd1 << F);
  localparam logic signed [ACC_W-1:0] THREE_A = ACC_W'(64'd3 << F);
  localparam logic signed [MXW-1:0]   TWO_M   = MXW'(64'd2 << F);
  localparam logic [LW-1:0]           ONE2    = LW'(64'd1 << TWO_F);
  localparam logic [OW-1:0]           ONE_O   = OW'(64'd1 << F);

  typedef enum logic [11:0] {
    S_IDLE = 12'b000000000001,
    S_MAPX = 12'b000000000010,
    S_MAPY = 12'b000000000100,
    S_SQ0  = 12'b000000001000,
    S_SQ1  = 12'b000000010000,
    S_SQ2  = 12'b000000100000,
    S_ROOT = 12'b000001000000,
    S_DIVX = 12'b000010000000,
    S_DIVY = 12'b000100000000,
    S_VEC  = 12'b001000000000,
    S_PROD = 12'b010000000000,
    S_FIN  = 12'b100000000000
  } state_t;

  state_t state;
  logic [3:0] step;

  logic [F+1:0]  scale_x;
  logic [F+1:0]  scale_y;
  logic [EPS_W-1:0] epsilon_sq;

  logic                  action;
  logic [COORD_BITS-1:0] px;
  logic [COORD_BITS-1:0] py;
  logic signed [MXW-1:0] mx;
  logic signed [MXW-1:0] my;
  logic [LW-1:0]         len;
  logic                  outside;
  logic [OW-1:0]         rad;
  logic signed [OW-1:0]  vx, vy, vz;
  logic signed [OW-1:0]  sx, sy, sz;
  logic signed [OW-1:0]  cx, cy, cz, dw;
  logic                  ovalid;
  logic signed [OW-1:0]  ox, oy, oz, ow_r;

  mac_op_t               mop;
  logic signed [MW-1:0]  ma, mb;
  logic signed [ACC_W-1:0] acc;
  iter_ctl_t             ictl;
  logic [LW-1:0]         radicand;
  logic [NW-1:0]         numer;
  logic [OW-1:0]         denom;
  logic                  idone;
  logic [OW-1:0]         ires;

  logic signed [ACC_W-1:0] mx_diff, my_diff;
  logic signed [MXW-1:0]   mx_c, my_c;
  logic [OW-1:0]           rad_c;
  logic [OW-1:0]           abs_mx, abs_my;
  logic [OW-1:0]           q_c;
  logic signed [OW-1:0]    rnd;
  logic [CW-1:0]           lhs, rhs;
  logic                    degen;

  function automatic logic signed [MW-1:0] ext_v(input logic signed [OW-1:0] v);
    ext_v = {{(MW-OW){v[OW-1]}}, v};
  endfunction

  function automatic logic signed [OW-1:0] round_sat(input logic signed [ACC_W-1:0] v);
    logic [ACC_W-1:0] mag;
    logic [ACC_W-1:0] rr;
    logic [OW-1:0]    lim;
    mag = v[ACC_W-1] ? ACC_W'(-v) : ACC_W'(v);
    rr  = (mag + ACC_W'(64'd1 << (F - 1))) >> F;
    lim = (rr > ACC_W'(ONE_O)) ? ONE_O : rr[OW-1:0];
    round_sat = v[ACC_W-1] ? OW'(-lim) : lim;
  endfunction

  // Mapped coordinates saturate at +-2.0; the product is never negative.
  always_comb begin
    mx_diff = acc - ONE_A;
    my_diff = ONE_A - acc;
    mx_c    = (acc > THREE_A) ? TWO_M : mx_diff[MXW-1:0];
    my_c    = (acc > THREE_A) ? -TWO_M : my_diff[MXW-1:0];
    len     = acc[LW-1:0];
    rad_c   = (ires == '0) ? OW'(1) : ires;
    abs_mx  = mx[MXW-1] ? OW'(-mx) : OW'(mx);
    abs_my  = my[MXW-1] ? OW'(-my) : OW'(my);
    q_c     = (ires > ONE_O) ? ONE_O : ires;
    rnd     = round_sat(acc);
    lhs     = CW'(acc[2*F+1:0]) << SH_L;
    rhs     = CW'(epsilon_sq) << SH_R;
    degen   = (lhs <= rhs);
  end

  // Operand selection for the shared multiplier and the root/divide unit.
  // The root starts while the accumulator still holds the squared radius.
  always_comb begin
    mop        = MAC_HOLD;
    ma         = '0;
    mb         = '0;
    ictl.start = 1'b0;
    ictl.mode  = ITER_SQRT;
    radicand   = (len > ONE2) ? len : ONE2 - len;
    denom      = (state == S_ROOT) ? rad_c : rad;
    numer      = (state == S_ROOT)
               ? ((NW'(abs_mx) << F) + NW'(rad_c >> 1))
               : ((NW'(abs_my) << F) + NW'(rad >> 1));
    case (state)
      S_MAPX: begin
        mop = MAC_LOAD;
        ma  = MW'({1'b0, px});
        mb  = MW'({1'b0, scale_x});
      end
      S_MAPY: begin
        mop = MAC_LOAD;
        ma  = MW'({1'b0, py});
        mb  = MW'({1'b0, scale_y});
      end
      S_SQ0: begin
        mop = MAC_LOAD;
        ma  = {{(MW-MXW){mx[MXW-1]}}, mx};
        mb  = {{(MW-MXW){mx[MXW-1]}}, mx};
      end
      S_SQ1: begin
        mop = MAC_ADD;
        ma  = {{(MW-MXW){my[MXW-1]}}, my};
        mb  = {{(MW-MXW){my[MXW-1]}}, my};
      end
      S_SQ2: begin
        ictl.start = 1'b1;
        ictl.mode  = ITER_SQRT;
      end
      S_ROOT: begin
        ictl.start = idone && outside;
        ictl.mode  = ITER_DIV;
      end
      S_DIVX: begin
        ictl.start = idone;
        ictl.mode  = ITER_DIV;
      end
      S_PROD: begin
        case (step)
          4'd0:  begin mop = MAC_LOAD; ma = ext_v(sy); mb = ext_v(vz); end
          4'd1:  begin mop = MAC_SUB;  ma = ext_v(sz); mb = ext_v(vy); end
          4'd2:  begin mop = MAC_LOAD; ma = ext_v(sz); mb = ext_v(vx); end
          4'd3:  begin mop = MAC_SUB;  ma = ext_v(sx); mb = ext_v(vz); end
          4'd4:  begin mop = MAC_LOAD; ma = ext_v(sx); mb = ext_v(vy); end
          4'd5:  begin mop = MAC_SUB;  ma = ext_v(sy); mb = ext_v(vx); end
          4'd6:  begin mop = MAC_LOAD; ma = ext_v(sx); mb = ext_v(vx); end
          4'd7:  begin mop = MAC_ADD;  ma = ext_v(sy); mb = ext_v(vy); end
          4'd8:  begin mop = MAC_ADD;  ma = ext_v(sz); mb = ext_v(vz); end
          4'd9:  begin mop = MAC_LOAD; ma = ext_v(cx); mb = ext_v(cx); end
          4'd10: begin mop = MAC_ADD;  ma = ext_v(cy); mb = ext_v(cy); end
          4'd11: begin mop = MAC_ADD;  ma = ext_v(cz); mb = ext_v(cz); end
          default: mop = MAC_HOLD;
        endcase
      end
      default: mop = MAC_HOLD;
    endcase
  end

  arb_mac #(.MW(MW)) u_mac (
    .clk (clk),
    .op  (mop),
    .a   (ma),
    .b   (mb),
    .acc (acc)
  );

  arb_iter #(.FRAC_BITS(F)) u_iter (
    .clk      (clk),
    .rst      (rst),
    .ctl      (ictl),
    .radicand (radicand),
    .numer    (numer),
    .denom    (denom),
    .done     (idone),
    .res      (ires)
  );

  assign pointer.ready  = (state == S_IDLE);
  assign rotation.valid = ovalid;
  assign rotation.rot_x = ox;
  assign rotation.rot_y = oy;
  assign rotation.rot_z = oz;
  assign rotation.rot_w = ow_r;

  // Configuration and sequencer control.
  always_ff @(posedge clk) begin
    if (rst) begin
      scale_x    <= (F+2)'(256);
      scale_y    <= (F+2)'(256);
      epsilon_sq <= EPS_W'(1);
      state      <= S_IDLE;
      step       <= '0;
      ovalid     <= 1'b0;
      sx         <= '0;
      sy         <= '0;
      sz         <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_SCALE_X:    scale_x    <= cfg_data[F+1:0];
          REG_SCALE_Y:    scale_y    <= cfg_data[F+1:0];
          REG_EPSILON_SQ: epsilon_sq <= cfg_data[EPS_W-1:0];
          default: ;
        endcase
      end
      if (ovalid && rotation.ready) ovalid <= 1'b0;
      case (state)
        S_IDLE: if (pointer.valid) state <= S_MAPX;
        S_MAPX: state <= S_MAPY;
        S_MAPY: state <= S_SQ0;
        S_SQ0:  state <= S_SQ1;
        S_SQ1:  state <= S_SQ2;
        S_SQ2:  state <= S_ROOT;
        S_ROOT: if (idone) state <= outside ? S_DIVX : S_VEC;
        S_DIVX: if (idone) state <= S_DIVY;
        S_DIVY: if (idone) state <= S_VEC;
        S_VEC: begin
          step <= '0;
          if (action == ACT_PRESS) begin
            sx    <= vx;
            sy    <= vy;
            sz    <= vz;
            state <= S_IDLE;
          end else begin
            state <= S_PROD;
          end
        end
        S_PROD: begin
          step <= step + 1'b1;
          if (step == 4'd12) state <= S_FIN;
        end
        S_FIN: begin
          if (!ovalid || rotation.ready) begin
            ovalid <= 1'b1;
            state  <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers.
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        action <= pointer.action;
        px     <= pointer.pointer_x;
        py     <= pointer.pointer_y;
      end
      S_MAPY: mx <= mx_c;
      S_SQ0:  my <= my_c;
      S_SQ2:  outside <= (len > ONE2);
      S_ROOT: begin
        if (idone) begin
          rad <= rad_c;
          if (!outside) begin
            vx <= OW'(mx);
            vy <= OW'(my);
            vz <= ires;
          end
        end
      end
      S_DIVX: if (idone) vx <= mx[MXW-1] ? OW'(-q_c) : q_c;
      S_DIVY: begin
        if (idone) begin
          vy <= my[MXW-1] ? OW'(-q_c) : q_c;
          vz <= '0;
        end
      end
      S_PROD: begin
        case (step)
          4'd2:  cx <= rnd;
          4'd4:  cy <= rnd;
          4'd6:  cz <= rnd;
          4'd9:  dw <= rnd;
          4'd12: begin
            if (degen) begin
              cx <= '0;
              cy <= '0;
              cz <= '0;
              dw <= ONE_O;
            end
          end
          default: ;
        endcase
      end
      S_FIN: begin
        if (!ovalid || rotation.ready) begin
          ox   <= cx;
          oy   <= cy;
          oz   <= cz;
          ow_r <= dw;
        end
      end
      default: ;
    endcase
  end
endmodule

// File: tb/sv/arcball_rotation_quaternion_unit_tb.sv
// Self-checking testbench for arcball_rotation_quaternion_unit: pointer requests in,
// rotation quaternions out, checked against an in-bench fixed-point predictor.
// Depends on arb_pkg, arb_if and the RTL of the block.
module arcball_rotation_quaternion_unit_tb import arb_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int COORD_BITS = 12;
  localparam int FRAC_BITS  = 16;
  localparam longint ONE    = longint'(1) << FRAC_BITS;
  localparam logic [CFG_INDEX_W-1:0] REG_SPARE = 2'd3;
  localparam int DRAIN_CYCLES = 120;
  localparam int STALL_LIMIT  = 6000;

  typedef struct {
    logic signed [FRAC_BITS+1:0] qx, qy, qz, qw;
  } quat_t;

  class stroke_scoreboard;
    longint unsigned sx, sy, eps;
    longint anchor_x, anchor_y, anchor_z;
    quat_t  pending_quats[$];
    int     errors;

    function new();
      sx = 256; sy = 256; eps = 1;
      anchor_x = 0; anchor_y = 0; anchor_z = 0;
      errors = 0;
    endfunction

    function void set_reg(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
      case (idx)
        REG_SCALE_X:    sx = data[FRAC_BITS+1:0];
        REG_SCALE_Y:    sy = data[FRAC_BITS+1:0];
        REG_EPSILON_SQ: eps = data;
        default: ;
      endcase
    endfunction

    function longint unsigned int_sqrt(longint unsigned v);
      longint unsigned res, bitv;
      res = 0;
      bitv = longint'(1) << 62;
      while (bitv > v) bitv >>= 2;
      while (bitv != 0) begin
        if (v >= res + bitv) begin
          v -= res + bitv;
          res = (res >> 1) + bitv;
        end else begin
          res >>= 1;
        end
        bitv >>= 2;
      end
      return res;
    endfunction

    function longint sat(longint v, longint lim);
      return v > lim ? lim : (v < -lim ? -lim : v);
    endfunction

    // Q.2F to Q.F, half away from zero.
    function longint narrow(longint v);
      longint mag;
      mag = v < 0 ? -v : v;
      mag = (mag + (ONE >> 1)) >>> FRAC_BITS;
      return v < 0 ? -mag : mag;
    endfunction

    function void sphere_point(longint px, longint py, output longint vx, vy, vz);
      longint mx, my, nx, ny;
      longint unsigned len, r;
      mx = sat(px * longint'(sx) - ONE, 2 * ONE);
      my = sat(ONE - py * longint'(sy), 2 * ONE);
      len = mx * mx + my * my;
      if (len > ONE * ONE) begin
        r = int_sqrt(len);
        if (r == 0) r = 1;
        nx = sat(longint'((((mx < 0 ? -mx : mx) << FRAC_BITS) + r / 2) / r), ONE);
        ny = sat(longint'((((my < 0 ? -my : my) << FRAC_BITS) + r / 2) / r), ONE);
        vx = mx < 0 ? -nx : nx;
        vy = my < 0 ? -ny : ny;
        vz = 0;
      end else begin
        vx = mx;
        vy = my;
        vz = longint'(int_sqrt(ONE * ONE - len));
      end
    endfunction

    function void note_request(logic act, logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
      longint ex, ey, ez, cx, cy, cz, dw;
      longint unsigned sum;
      quat_t q;
      if (act == ACT_PRESS) begin
        sphere_point(px, py, anchor_x, anchor_y, anchor_z);
        return;
      end
      sphere_point(px, py, ex, ey, ez);
      cx = sat(narrow(anchor_y * ez - anchor_z * ey), ONE);
      cy = sat(narrow(anchor_z * ex - anchor_x * ez), ONE);
      cz = sat(narrow(anchor_x * ey - anchor_y * ex), ONE);
      dw = sat(narrow(anchor_x * ex + anchor_y * ey + anchor_z * ez), ONE);
      sum = cx * cx + cy * cy + cz * cz;
      if (sum <= eps) begin
        cx = 0; cy = 0; cz = 0; dw = ONE;
      end
      q.qx = cx[FRAC_BITS+1:0];
      q.qy = cy[FRAC_BITS+1:0];
      q.qz = cz[FRAC_BITS+1:0];
      q.qw = dw[FRAC_BITS+1:0];
      pending_quats.push_back(q);
    endfunction

    task report(string msg);
      $display("mismatch at %0t: %s", $realtime, msg);
      errors++;
    endtask

    task check_result(quat_t got);
      quat_t want;
      if (pending_quats.size() == 0) begin
        report("rotation result with no request outstanding");
        return;
      end
      want = pending_quats.pop_front();
      if (got.qx !== want.qx) report($sformatf("rot_x %0d, expected %0d", got.qx, want.qx));
      if (got.qy !== want.qy) report($sformatf("rot_y %0d, expected %0d", got.qy, want.qy));
      if (got.qz !== want.qz) report($sformatf("rot_z %0d, expected %0d", got.qz, want.qz));
      if (got.qw !== want.qw) report($sformatf("rot_w %0d, expected %0d", got.qw, want.qw));
    endtask
  endclass

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  arb_in_if  #(.COORD_BITS(COORD_BITS)) pointer_if ();
  arb_out_if #(.FRAC_BITS(FRAC_BITS))   rotation_if ();

  arcball_rotation_quaternion_unit #(.COORD_BITS(COORD_BITS), .FRAC_BITS(FRAC_BITS)) dut (
    .clk(clk), .rst(rst), .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .pointer(pointer_if.sink), .rotation(rotation_if.source)
  );

  stroke_scoreboard sb = new();
  int burst_left = 0;
  int cycle_count = 0;
  int hold_left = 0;
  int pattern_left = 0;
  int pattern_mode = 0;
  int quiet_cycles = 0;
  quat_t got_quat;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  task cfg_write(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    @(posedge clk);
    sb.set_reg(idx, data);
  endtask

  task configure(logic [CFG_DATA_W-1:0] sx, logic [CFG_DATA_W-1:0] sy,
                 logic [CFG_DATA_W-1:0] eps);
    cfg_write(REG_SCALE_X, sx);
    cfg_write(REG_SCALE_Y, sy);
    cfg_write(REG_SPARE, $urandom);
    cfg_write(REG_EPSILON_SQ, eps);
    cfg_we <= 1'b0;
  endtask

  task send_request(logic act, logic [COORD_BITS-1:0] px, logic [COORD_BITS-1:0] py);
    int gap;
    if (burst_left == 0) begin
      gap = $urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 10);
      burst_left = $urandom_range(1, 12);
      if (gap > 0) begin
        pointer_if.valid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    burst_left--;
    pointer_if.valid     <= 1'b1;
    pointer_if.action    <= act;
    pointer_if.pointer_x <= px;
    pointer_if.pointer_y <= py;
    do @(posedge clk); while (!(pointer_if.valid && pointer_if.ready));
    sb.note_request(act, px, py);
  endtask

  // Drop valid and let the last result and any press still in flight finish.
  task settle();
    pointer_if.valid <= 1'b0;
    burst_left = 0;
    while (sb.pending_quats.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  function logic [COORD_BITS-1:0] near_coord(longint unsigned scale);
    longint unsigned span;
    span = scale == 0 ? 4095 : (2 * ONE) / scale + 8;
    if (span > 4095) span = 4095;
    return COORD_BITS'($urandom_range(0, int'(span)));
  endfunction

  task random_phase(int count);
    int sent, drags;
    sent = 0;
    while (sent < count) begin
      if ($urandom_range(0, 6) == 0) begin
        // Unstructured noise over the full coordinate range.
        send_request($urandom_range(0, 1) ? ACT_DRAG : ACT_PRESS,
                     COORD_BITS'($urandom), COORD_BITS'($urandom));
        sent++;
      end else begin
        send_request(ACT_PRESS, near_coord(sb.sx), near_coord(sb.sy));
        drags = $urandom_range(1, 5);
        repeat (drags) send_request(ACT_DRAG, near_coord(sb.sx), near_coord(sb.sy));
        sent += drags + 1;
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      rotation_if.ready <= 1'b0;
    end else begin
      if (rotation_if.valid && rotation_if.ready) begin
        got_quat.qx = rotation_if.rot_x;
        got_quat.qy = rotation_if.rot_y;
        got_quat.qz = rotation_if.rot_z;
        got_quat.qw = rotation_if.rot_w;
        sb.check_result(got_quat);
      end
      cycle_count++;
      // One long hold-off while the sender keeps offering, to back the block up.
      if (cycle_count == 6000) hold_left = 500;
      if (hold_left > 0) begin
        hold_left--;
        rotation_if.ready <= 1'b0;
      end else begin
        if (pattern_left == 0) begin
          pattern_mode = $urandom_range(0, 2);
          pattern_left = $urandom_range(20, 200);
        end
        pattern_left--;
        case (pattern_mode)
          0:       rotation_if.ready <= 1'b1;
          1:       rotation_if.ready <= $urandom_range(0, 3) != 0;
          default: rotation_if.ready <= $urandom_range(0, 4) == 0;
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (pointer_if.valid && pointer_if.ready) ||
        (rotation_if.valid && rotation_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= STALL_LIMIT) begin
      $display("arcball_rotation_quaternion_unit regression: fail");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    rst <= 1'b1;
    cfg_we <= 1'b0;
    cfg_index <= REG_SCALE_X;
    cfg_data <= '0;
    pointer_if.valid <= 1'b0;
    pointer_if.action <= ACT_PRESS;
    pointer_if.pointer_x <= '0;
    pointer_if.pointer_y <= '0;
    repeat (5) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset scales of 256 map pixels 0..512 across the ball.
    send_request(ACT_DRAG, 100, 100);     // drag before any press gives identity
    send_request(ACT_PRESS, 256, 256);    // centre of the ball, z at its top
    send_request(ACT_DRAG, 256, 256);     // same point: degenerate rotation
    send_request(ACT_DRAG, 300, 256);
    send_request(ACT_DRAG, 256, 200);     // drags leave the start vector alone
    send_request(ACT_PRESS, 0, 0);        // outside the circle, top-left corner
    send_request(ACT_DRAG, 4095, 4095);   // saturated far corner
    send_request(ACT_PRESS, 0, 4095);
    send_request(ACT_DRAG, 4095, 0);
    send_request(ACT_PRESS, 256, 100);
    send_request(ACT_DRAG, 200, 300);
    send_request(ACT_PRESS, 4095, 256);
    send_request(ACT_DRAG, 256, 4095);
    send_request(ACT_PRESS, 128, 128);
    send_request(ACT_DRAG, 384, 128);
    send_request(ACT_DRAG, 2730, 1365);
    settle();

    configure(32, 32, 1);
    random_phase(110);
    settle();
    configure(0, 131072, 0);
    random_phase(100);
    settle();
    configure(32'hFFFF_FFFF, 64, 1000);
    random_phase(100);
    settle();
    configure(48, 40, 32'd65536);
    random_phase(110);
    settle();
    configure(131072, 0, 32'hFFFF_FFFF);
    random_phase(100);
    settle();
    configure(100, 200, 0);
    random_phase(110);
    settle();

    if (sb.errors == 0) begin
      $display("arcball_rotation_quaternion_unit regression: pass");
    end else begin
      $display("arcball_rotation_quaternion_unit regression: fail");
    end
    $finish;
  end
endmodule
